// ===== hdl/mfq_pkg.sv =====
// Shared types, codes and sizes of the feedback queue scheduler.
package mfq_pkg;

  localparam int CMD_W   = 2;
  localparam int PID_W   = 5;
  localparam int OUTC_W  = 2;
  localparam int ACT_W   = 3;
  localparam int LVL_W   = 2;
  localparam int QNT_W   = 4;
  localparam int CFG_IX_W = 2;

  localparam int NUM_LEVELS        = 4;
  localparam int DEF_NUM_PROCESSES = 16;

  localparam logic [LVL_W-1:0] LAST_LEVEL = 2'd3;
  localparam logic [QNT_W-1:0] QNT_MAX    = 4'd15;

  localparam logic [QNT_W-1:0] QNT_RESET [NUM_LEVELS] = '{4'd1, 4'd2, 4'd4, 4'd8};

  // command codes
  localparam logic [CMD_W-1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNBLOCK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd2;

  // report outcome codes
  localparam logic [OUTC_W-1:0] OUTC_RAN      = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FINISHED = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_BLOCKED  = 2'd2;

  // result status codes
  localparam logic RES_ACCEPTED = 1'b0;
  localparam logic RES_REJECTED = 1'b1;

  // result action codes
  localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_KEPT     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEMOTED  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ROTATED  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVED  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BLOCKED  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_QUEUED   = 3'd6;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/mfq_if.sv =====
// Command and result channel interfaces of the feedback queue scheduler.
interface mfq_cmd_if import mfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PID_W-1:0]  process_id;
  logic [OUTC_W-1:0] outcome;

  modport source (output valid, command, process_id, outcome, input ready);
  modport sink   (input valid, command, process_id, outcome, output ready);
endinterface

interface mfq_res_if import mfq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [ACT_W-1:0] action;
  logic [PID_W-1:0] next_process;
  logic [LVL_W-1:0] next_level;

  modport source (output valid, status, action, next_process, next_level, input ready);
  modport sink   (input valid, status, action, next_process, next_level, output ready);
endinterface

// ===== hdl/mfq_ctrl.sv =====
// Sequencer of the feedback queue scheduler: accept, update, deliver.
module mfq_ctrl import mfq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready   = (state == ST_IDLE);
  assign ctl.load   = in_ready && in_valid;
  assign ctl.exec   = (state == ST_EXEC);
  assign ctl.finish = (state == ST_FIN) && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.load) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_exec: assert property (@(posedge clk) disable iff (rst) ctl.load |=> ctl.exec)
    else $error("accepted item not followed by update cycle");
  a_exec_fin: assert property (@(posedge clk) disable iff (rst) ctl.exec |=> state == ST_FIN)
    else $error("update cycle not followed by delivery");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FIN && !stat.out_free) |=> (state == ST_FIN && !in_ready))
    else $error("result dropped while output register busy");

endmodule

// ===== hdl/mfq_dp.sv =====
// Queue memory, per-process state and result register of the scheduler.
module mfq_dp import mfq_pkg::*; #(
  parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [QNT_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]    command,
  input  logic [PID_W-1:0]    process_id,
  input  logic [OUTC_W-1:0]   outcome,
  input  ctl_cmd_t            ctl,
  output dp_stat_t            stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                status,
  output logic [ACT_W-1:0]    action,
  output logic [PID_W-1:0]    next_process,
  output logic [LVL_W-1:0]    next_level
);

  localparam int PW     = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int SW     = PW + 1;
  localparam int CW     = $clog2(NUM_PROCESSES + 1);
  localparam int QAW    = LVL_W + PW;
  localparam int PDEPTH = 1 << PW;
  localparam int QDEPTH = NUM_LEVELS * PDEPTH;
  localparam logic [PW-1:0] LAST_IX  = PW'(NUM_PROCESSES - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(NUM_PROCESSES);
  localparam logic [SW-1:0] SLOT_N   = SW'(NUM_PROCESSES);

  // configuration
  logic [QNT_W-1:0] quantum [NUM_LEVELS];

  // queue store and per-process store
  logic [PID_W-1:0]       qmem [QDEPTH];
  logic [PID_W-1:0]       q_rd;
  logic [LVL_W+QNT_W-1:0] pmem [PDEPTH];
  logic [LVL_W+QNT_W-1:0] p_rd;

  // queue pointers and marks
  logic [PW-1:0]     head  [NUM_LEVELS];
  logic [CW-1:0]     count [NUM_LEVELS];
  logic [PDEPTH-1:0] active;
  logic [PDEPTH-1:0] blocked;

  // cached head of the highest non-empty level
  logic             cur_valid;
  logic [LVL_W-1:0] cur_level;
  logic [PID_W-1:0] cur_head;

  // latched item
  logic [CMD_W-1:0]  cmd_r;
  logic [PID_W-1:0]  pid_r;
  logic [OUTC_W-1:0] outcome_r;
  logic              pid_ok_r;
  logic [PW-1:0]     pid_ix_r;

  // update results held for delivery
  logic             status_r;
  logic [ACT_W-1:0] action_r;
  logic             nonempty_r;
  logic [LVL_W-1:0] lvn_r;
  logic             fwd_r;
  logic [PID_W-1:0] fwd_data_r;

  // accept-side decode
  logic          pid_ok_in;
  logic [31:0]   pid_m1;
  logic [31:0]   head_m1;
  logic [PW-1:0] pid_ix_in;
  logic [PW-1:0] head_ix;
  logic [PW-1:0] p_raddr;

  assign pid_ok_in = (process_id != '0) && (32'(process_id) <= NUM_PROCESSES);
  assign pid_m1    = 32'(process_id) - 32'd1;
  assign head_m1   = 32'(cur_head) - 32'd1;
  assign pid_ix_in = pid_m1[PW-1:0];
  assign head_ix   = head_m1[PW-1:0];
  assign p_raddr   = (command == CMD_REPORT) ? head_ix : pid_ix_in;

  // update-cycle logic
  logic [LVL_W-1:0]       p_level;
  logic [QNT_W-1:0]       p_quant;
  logic [QNT_W-1:0]       q_inc;
  logic [LVL_W-1:0]       dest;
  logic                   reached;
  logic                   do_pop;
  logic                   do_push;
  logic                   push_ok;
  logic [LVL_W-1:0]       push_lv;
  logic [PID_W-1:0]       push_data;
  logic [SW-1:0]          slot_sum;
  logic [SW-1:0]          slot_w;
  logic [PW-1:0]          slot;
  logic [PW-1:0]          head1 [NUM_LEVELS];
  logic [CW-1:0]          count1 [NUM_LEVELS];
  logic [PW-1:0]          head_next [NUM_LEVELS];
  logic [CW-1:0]          count_next [NUM_LEVELS];
  logic                   ex_status;
  logic [ACT_W-1:0]       ex_action;
  logic                   p_we;
  logic [LVL_W+QNT_W-1:0] p_wdata;
  logic [PW-1:0]          mark_ix;
  logic                   act_set, act_clr, blk_set, blk_clr;
  logic                   nonempty;
  logic [LVL_W-1:0]       lvn;
  logic [QAW-1:0]         push_addr;
  logic [QAW-1:0]         new_addr;
  logic                   fwd;

  assign p_level = p_rd[QNT_W +: LVL_W];
  assign p_quant = p_rd[QNT_W-1:0];
  assign q_inc   = (p_quant == QNT_MAX) ? p_quant : p_quant + QNT_W'(1);
  assign dest    = (cur_level == LAST_LEVEL) ? cur_level : cur_level + LVL_W'(1);
  assign reached = (q_inc >= quantum[cur_level]);
  assign mark_ix = (cmd_r == CMD_REPORT) ? head_ix : pid_ix_r;

  always_comb begin
    do_pop    = 1'b0;
    do_push   = 1'b0;
    push_lv   = '0;
    push_data = pid_r;
    ex_status = RES_REJECTED;
    ex_action = ACT_NONE;
    p_we      = 1'b0;
    p_wdata   = '0;
    act_set   = 1'b0;
    act_clr   = 1'b0;
    blk_set   = 1'b0;
    blk_clr   = 1'b0;

    // pop decision and push target
    case (cmd_r)
      CMD_ARRIVE: begin
        push_lv = '0;
      end
      CMD_UNBLOCK: begin
        push_lv = p_level;
      end
      CMD_REPORT: begin
        push_lv   = dest;
        push_data = cur_head;
        if (cur_valid) begin
          if (outcome_r == OUTC_FINISHED || outcome_r == OUTC_BLOCKED) do_pop = 1'b1;
          if (outcome_r == OUTC_RAN && reached) do_pop = 1'b1;
        end
      end
      default: begin
        push_lv = '0;
      end
    endcase

    // pointers after the pop
    for (int l = 0; l < NUM_LEVELS; l++) begin
      head1[l]  = head[l];
      count1[l] = count[l];
      if (do_pop && cur_level == LVL_W'(l)) begin
        head1[l]  = (head[l] == LAST_IX) ? '0 : head[l] + PW'(1);
        count1[l] = count[l] - CW'(1);
      end
    end

    push_ok  = (count1[push_lv] < CNT_FULL);
    slot_sum = SW'(head1[push_lv]) + SW'(count1[push_lv]);
    slot_w   = (slot_sum >= SLOT_N) ? slot_sum - SLOT_N : slot_sum;
    slot     = slot_w[PW-1:0];

    case (cmd_r)
      CMD_ARRIVE: begin
        if (pid_ok_r && !active[pid_ix_r] && push_ok) begin
          do_push   = 1'b1;
          p_we      = 1'b1;
          p_wdata   = '0;
          act_set   = 1'b1;
          blk_clr   = 1'b1;
          ex_status = RES_ACCEPTED;
          ex_action = ACT_QUEUED;
        end
      end
      CMD_UNBLOCK: begin
        if (pid_ok_r && active[pid_ix_r] && blocked[pid_ix_r] && push_ok) begin
          do_push   = 1'b1;
          blk_clr   = 1'b1;
          ex_status = RES_ACCEPTED;
          ex_action = ACT_QUEUED;
        end
      end
      CMD_REPORT: begin
        if (cur_valid) begin
          ex_status = RES_ACCEPTED;
          case (outcome_r)
            OUTC_FINISHED: begin
              p_we      = 1'b1;
              p_wdata   = {p_level, QNT_W'(0)};
              act_clr   = 1'b1;
              blk_clr   = 1'b1;
              ex_action = ACT_REMOVED;
            end
            OUTC_BLOCKED: begin
              p_we      = 1'b1;
              p_wdata   = {p_level, QNT_W'(0)};
              blk_set   = 1'b1;
              ex_action = ACT_BLOCKED;
            end
            OUTC_RAN: begin
              p_we = 1'b1;
              if (reached) begin
                do_push   = push_ok;
                p_wdata   = {dest, QNT_W'(0)};
                ex_action = (cur_level == LAST_LEVEL) ? ACT_ROTATED : ACT_DEMOTED;
              end else begin
                p_wdata   = {p_level, q_inc};
                ex_action = ACT_KEPT;
              end
            end
            default: begin
              ex_action = ACT_NONE;
            end
          endcase
        end
      end
      default: begin
        ex_status = RES_REJECTED;
      end
    endcase

    // pointers after the push
    for (int l = 0; l < NUM_LEVELS; l++) begin
      head_next[l]  = head1[l];
      count_next[l] = count1[l];
      if (do_push && push_lv == LVL_W'(l)) count_next[l] = count1[l] + CW'(1);
    end

    // highest non-empty level afterwards
    nonempty = 1'b0;
    lvn      = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count_next[l] != '0) begin
        nonempty = 1'b1;
        lvn      = LVL_W'(l);
      end
    end

    push_addr = {push_lv, slot};
    new_addr  = {lvn, head_next[lvn]};
    fwd       = do_push && (push_addr == new_addr);
  end

  logic [PID_W-1:0] fin_head;
  assign fin_head      = fwd_r ? fwd_data_r : q_rd;
  assign stat.out_free = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        quantum[l] <= QNT_RESET[l];
        head[l]    <= '0;
        count[l]   <= '0;
      end
      active    <= '0;
      blocked   <= '0;
      cur_valid <= 1'b0;
      cur_level <= '0;
      cur_head  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) quantum[cfg_index] <= cfg_data;
      if (ctl.exec) begin
        head  <= head_next;
        count <= count_next;
        if (act_set) active[mark_ix]  <= 1'b1;
        if (act_clr) active[mark_ix]  <= 1'b0;
        if (blk_set) blocked[mark_ix] <= 1'b1;
        if (blk_clr) blocked[mark_ix] <= 1'b0;
      end
      if (ctl.finish) begin
        cur_valid <= nonempty_r;
        cur_level <= lvn_r;
        cur_head  <= nonempty_r ? fin_head : '0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= command;
      pid_r     <= process_id;
      outcome_r <= outcome;
      pid_ok_r  <= pid_ok_in;
      pid_ix_r  <= pid_ix_in;
      p_rd      <= pmem[p_raddr];
    end
    if (ctl.exec) begin
      if (do_push) qmem[push_addr] <= push_data;
      if (p_we) pmem[mark_ix] <= p_wdata;
      q_rd       <= qmem[new_addr];
      status_r   <= ex_status;
      action_r   <= ex_action;
      nonempty_r <= nonempty;
      lvn_r      <= lvn;
      fwd_r      <= fwd;
      fwd_data_r <= push_data;
    end
    if (ctl.finish) begin
      status       <= status_r;
      action       <= action_r;
      next_process <= nonempty_r ? fin_head : '0;
      next_level   <= nonempty_r ? lvn_r : '0;
    end
  end

  a_queued_match: assert property (@(posedge clk) disable iff (rst)
      $countones(active & ~blocked) ==
      (32'(count[0]) + 32'(count[1]) + 32'(count[2]) + 32'(count[3])))
    else $error("queued entries disagree with runnable processes");
  a_blocked_active: assert property (@(posedge clk) disable iff (rst)
      (blocked & ~active) == '0)
    else $error("blocked mark on inactive process");
  a_head_cache: assert property (@(posedge clk) disable iff (rst)
      ctl.finish |=> (cur_valid == (count[0] != '0 || count[1] != '0 ||
                                    count[2] != '0 || count[3] != '0)))
    else $error("cached head disagrees with level counts");

endmodule

// ===== hdl/multilevel_feedback_queue_scheduler.sv =====
// Top level of the four-level feedback queue scheduler.
//
// Four FIFO levels of process numbers (1 to NUM_PROCESSES), level 0 served
// first. Each command item (arrive, unblock, report) yields exactly one
// result item with status, action and the head that would run next. The
// accept edge reads the per-process store, an update cycle moves the queue
// pointers and writes the queue memory while it reads the new head, and a
// delivery cycle loads the result register. A waiting result holds the
// sequencer in delivery until taken. No clearing pass follows reset: data
// read from the queue store is used only from entries already written.
// Quantum registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no item is in flight, as the block
// itself does not enforce this.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; #(
  parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [QNT_W-1:0]    cfg_data,
  mfq_cmd_if.sink             cmd_ch,
  mfq_res_if.source           result_ch
);

  ctl_cmd_t ctl;
  dp_stat_t stat;
  logic     in_ready;

  // hand the command ready back to the source
  assign cmd_ch.ready = in_ready;

  mfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  mfq_dp #(
    .NUM_PROCESSES (NUM_PROCESSES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (cmd_ch.command),
    .process_id   (cmd_ch.process_id),
    .outcome      (cmd_ch.outcome),
    .ctl          (ctl),
    .stat         (stat),
    .out_ready    (result_ch.ready),
    .out_valid    (result_ch.valid),
    .status       (result_ch.status),
    .action       (result_ch.action),
    .next_process (result_ch.next_process),
    .next_level   (result_ch.next_level)
  );

endmodule
